// ----- hw/rtl/lkvc_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// lkvc_pkg
// Shared types and constants of the LRU key-value cache.
// ============================================================================
package lkvc_pkg;

    localparam int MAX_ENTRIES_DEF = 16;
    localparam int KEY_BITS_DEF    = 32;
    localparam int CFG_W           = 5;
    localparam int DATA_W          = 32;

    localparam logic [CFG_W-1:0]  CAP_RESET = 5'd16;
    localparam logic [DATA_W-1:0] MINUS_ONE = 32'hFFFF_FFFF;

    localparam logic OPC_GET = 1'b0;
    localparam logic OPC_PUT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_UPD
    } t_state;

    // Control broadcast from the sequencer to every cell.
    typedef struct packed {
        logic look;    // compare phase: register the key match
        logic upd;     // update phase: shift the chain
        logic hit;     // some cell matched the request key
        logic put;     // request is a put
    } t_cell_ctl;

endpackage

// ----- hw/rtl/lkvc_cell.sv -----
`timescale 1ns / 1ps
// ============================================================================
// lkvc_cell
// One slot of the recency chain: holds a key, a value and a valid bit, and
// takes its upstream neighbor's contents when the chain shifts.
// ============================================================================
module lkvc_cell
    import lkvc_pkg::*;
#(
    parameter int IDX = 0,
    parameter int KW  = 32,
    parameter int CW  = 5
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cell_ctl         i_ctl,
    input  logic [CW-1:0]     i_cap,
    input  logic [KW-1:0]     i_req_key,
    input  logic              i_tail_hit,
    input  logic              i_prev_valid,
    input  logic [KW-1:0]     i_prev_key,
    input  logic [DATA_W-1:0] i_prev_val,
    output logic              o_valid,
    output logic [KW-1:0]     o_key,
    output logic [DATA_W-1:0] o_val,
    output logic              o_match
);

    logic              r_valid;
    logic [KW-1:0]     r_key;
    logic [DATA_W-1:0] r_val;
    logic              r_match;

    logic n_shift;
    logic n_keep_valid;

    // On a hit only the cells at or above the hit position move down by one.
    // On a put of a new key every cell moves, and cells past the capacity
    // drop out.
    always_comb begin
        n_shift      = i_ctl.upd && (i_ctl.hit ? i_tail_hit : i_ctl.put);
        n_keep_valid = i_prev_valid && (i_ctl.hit || (CW'(IDX) < i_cap));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_match <= 1'b0;
        end else begin
            if (i_ctl.look) begin
                r_match <= r_valid && (r_key == i_req_key);
            end
            if (n_shift) begin
                r_valid <= n_keep_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_shift) begin
            r_key <= i_prev_key;
            r_val <= i_prev_val;
        end
    end

    assign o_valid = r_valid;
    assign o_key   = r_key;
    assign o_val   = r_val;
    assign o_match = r_match;

endmodule

// ----- hw/rtl/lru_key_value_cache.sv -----
`timescale 1ns / 1ps
// ============================================================================
// lru_key_value_cache
// Fully associative key-value cache kept in least-recently-used order.
// ============================================================================
// Usage:
// Requests enter on i_valid / o_stall with i_opcode (get or put), i_lookup_key
// and i_write_value. Every request yields one result beat on o_valid /
// i_stall carrying o_found and o_read_value (-1 on a miss and on any put).
// The entries sit in a chain of cells ordered by recency, cell 0 the most
// recent. A request passes through two steps: a compare step in which every
// cell compares its key, and an update step in which the chain shifts and
// the result is registered. A new request is accepted only while idle or in
// the update step of the previous one; the compare/shift pair sets this.
// A stalled result holds the block in its update step until the beat is
// taken, so nothing is lost. The capacity is written through i_cfg_wr_en /
// i_cfg_wr_data; the user must write it only while idle (not enforced).
// 0 acts as 1 and values above the entry count act as the entry count. Reset
// empties the cache and sets the capacity to 16; no clearing pass is needed.
// ============================================================================
module lru_key_value_cache
    import lkvc_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int KEY_BITS    = KEY_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [CFG_W-1:0]  i_cfg_wr_data,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_opcode,
    input  logic [31:0]       i_lookup_key,
    input  logic [31:0]       i_write_value,
    output logic              o_valid,
    input  logic              i_stall,
    output logic              o_found,
    output logic [31:0]       o_read_value
);

    localparam int KW = (KEY_BITS < 32) ? KEY_BITS : 32;
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    t_state r_state, n_state;

    logic [CFG_W-1:0]  r_cfg;
    logic              r_op;
    logic [KW-1:0]     r_key;
    logic [DATA_W-1:0] r_wdata;
    logic              r_out_valid;
    logic              r_out_found;
    logic [DATA_W-1:0] r_out_data;

    logic          w_accept;
    logic          w_finish;
    logic          w_out_free;
    logic [CW-1:0] w_cap;
    t_cell_ctl     w_ctl;

    logic [MAX_ENTRIES-1:0] w_valid;
    logic [MAX_ENTRIES-1:0] w_match;
    logic [MAX_ENTRIES-1:0] w_tail;
    logic [KW-1:0]          w_key [MAX_ENTRIES];
    logic [DATA_W-1:0]      w_val [MAX_ENTRIES];
    logic                   w_hit;
    logic [DATA_W-1:0]      w_hit_val;
    logic [DATA_W-1:0]      w_head_val;

    assign w_out_free = !r_out_valid || !i_stall;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_LOOK;
                end
            end
            ST_LOOK: n_state = ST_UPD;
            ST_UPD: begin
                if (w_out_free) begin
                    n_state = i_valid ? ST_LOOK : ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb begin
        o_stall  = 1'b1;
        w_finish = 1'b0;
        w_ctl    = '0;
        case (r_state)
            ST_IDLE: o_stall = 1'b0;
            ST_LOOK: w_ctl.look = 1'b1;
            ST_UPD: begin
                w_finish  = w_out_free;
                o_stall   = !w_out_free;
                w_ctl.upd = w_out_free;
            end
            default: o_stall = 1'b1;
        endcase
        w_ctl.hit = w_hit;
        w_ctl.put = (r_op == OPC_PUT);
    end

    assign w_accept = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cfg       <= CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_cfg <= i_cfg_wr_data;
            end
            if (w_finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op    <= i_opcode;
            r_key   <= i_lookup_key[KW-1:0];
            r_wdata <= i_write_value;
        end
        if (w_finish) begin
            r_out_found <= w_hit;
            r_out_data  <= (r_op == OPC_GET && w_hit) ? w_hit_val : MINUS_ONE;
        end
    end

    always_comb begin
        if (r_cfg == '0) begin
            w_cap = CW'(1);
        end else if (32'(r_cfg) > MAX_ENTRIES) begin
            w_cap = CW'(MAX_ENTRIES);
        end else begin
            w_cap = CW'(r_cfg);
        end
    end

    // Keys are unique among valid cells, so at most one match bit is set.
    always_comb begin
        w_hit_val = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            w_tail[i] = |(w_match >> i);
            if (w_match[i]) begin
                w_hit_val = w_hit_val | w_val[i];
            end
        end
        w_hit = |w_match;
    end

    assign w_head_val = (r_op == OPC_PUT) ? r_wdata : w_hit_val;

    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        logic              w_pv;
        logic [KW-1:0]     w_pk;
        logic [DATA_W-1:0] w_pd;

        if (g == 0) begin : g_head
            assign w_pv = 1'b1;
            assign w_pk = r_key;
            assign w_pd = w_head_val;
        end else begin : g_link
            assign w_pv = w_valid[g-1];
            assign w_pk = w_key[g-1];
            assign w_pd = w_val[g-1];
        end

        lkvc_cell #(
            .IDX (g),
            .KW  (KW),
            .CW  (CW)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_cap        (w_cap),
            .i_req_key    (r_key),
            .i_tail_hit   (w_tail[g]),
            .i_prev_valid (w_pv),
            .i_prev_key   (w_pk),
            .i_prev_val   (w_pd),
            .o_valid      (w_valid[g]),
            .o_key        (w_key[g]),
            .o_val        (w_val[g]),
            .o_match      (w_match[g])
        );
    end

    assign o_valid      = r_out_valid;
    assign o_found      = r_out_found;
    assign o_read_value = r_out_data;

endmodule
